// ----- design/mrs_pkg.sv -----
// Shared types and constants for the mission return supervisor.
`default_nettype none

package mrs_pkg;

  // Largest count the required-specials register may hold
  localparam int unsigned MAX_SPECIALS = 15;
  localparam int unsigned REQ_W        = 4;
  localparam int unsigned FOUND_W      = 8;

  // Command codes
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SEARCH = 3'd1,
    MODE_WAIT   = 3'd2,
    MODE_PLAN   = 3'd3,
    MODE_EXEC   = 3'd4,
    MODE_DONE   = 3'd5,
    MODE_ERROR  = 3'd6,
    MODE_CANCEL = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    RSN_NONE     = 3'd0,
    RSN_CANCEL   = 3'd1,
    RSN_NOFRONT  = 3'd2,
    RSN_BADSTART = 3'd3,
    RSN_RETURNED = 3'd4,
    RSN_NOROUTE  = 3'd5
  } reason_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               mission_on;
    logic [FOUND_W-1:0] specials_found;
    logic               no_frontier;
    logic               nav_idle;
    logic               home_known;
    logic               at_home;
    logic               plan_ready;
    logic               plan_running;
  } in_item_t;

  typedef struct packed {
    mode_t   mode;
    reason_t reason;
    logic    stop_autonomy;
    logic    stop_motors;
    logic    block_actions;
    logic    clear_plan;
    logic    plan_return;
    logic    run_return;
    logic    returning;
  } out_item_t;

  // Handshake between the input register and the result register
  typedef struct packed {
    logic item_valid;  // input register holds a beat
    logic take_ok;     // result register can load this cycle
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- design/mission_return_supervisor_fsm_top.sv -----
// Path: an accepted beat passes through the input register and then the result register to out_valid.
// Throughput: one beat per cycle while out_stall is low; the state update is a single pass through the FSM logic
//   between the input register and the result register.
// Back-pressure: in_stall rises only when the input register is full and the result
//   register is stalled.
// Reset: synchronous, active low; mission state to idle, required specials to 1.
`default_nettype none

module mission_return_supervisor_fsm_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire mrs_pkg::in_item_t         in_data,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output mrs_pkg::out_item_t             out_data,
  // configuration: required specials
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [mrs_pkg::REQ_W-1:0] cfg_data
);

  logic                      take_ok;
  mrs_pkg::pipe_ctl_t        ctl;
  mrs_pkg::in_item_t         item;
  mrs_pkg::out_item_t        result;
  logic [mrs_pkg::REQ_W-1:0] req_specials;

  // Clamped required-specials count; written only while the block is quiet is a user duty: cfg_ready is tied high
  mrs_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .req_specials (req_specials)
  );

  // Stage 1: register the incoming beat
  mrs_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take_ok  (take_ok),
    .ctl      (ctl),
    .item     (item)
  );

  // FSM: mission state advances in the same cycle the beat moves to the result register,
  // so the next beat in stage 1 already sees the updated state
  mrs_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .item         (item),
    .req_specials (req_specials),
    .result       (result)
  );

  // Stage 2: result register
  mrs_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (ctl.item_valid),
    .result     (result),
    .take_ok    (take_ok),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ----- design/mrs_cfg.sv -----
// Required-specials configuration register with clamping on write.
`default_nettype none

module mrs_cfg (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [mrs_pkg::REQ_W-1:0] cfg_data,
  output logic [mrs_pkg::REQ_W-1:0]     req_specials
);

  logic [mrs_pkg::REQ_W-1:0] req_r;
  logic [mrs_pkg::REQ_W-1:0] req_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    req_nxt = cfg_data;
    if (cfg_data == '0) begin
      req_nxt = mrs_pkg::REQ_W'(1);
    end else if (32'(cfg_data) > mrs_pkg::MAX_SPECIALS) begin
      req_nxt = mrs_pkg::REQ_W'(mrs_pkg::MAX_SPECIALS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= mrs_pkg::REQ_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      req_r <= req_nxt;
    end
  end

  assign req_specials = req_r;

endmodule

`default_nettype wire

// ----- design/mrs_in_stage.sv -----
// Input register: captures one beat and holds it until the result stage takes it.
`default_nettype none

module mrs_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mrs_pkg::in_item_t  in_data,
  input  wire logic               take_ok,
  output mrs_pkg::pipe_ctl_t      ctl,
  output mrs_pkg::in_item_t       item
);

  logic              vld_r;
  mrs_pkg::in_item_t data_r;
  logic              accept;

  assign in_stall = vld_r && !take_ok;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept) begin
      vld_r <= 1'b1;
    end else if (take_ok) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data;
    end
  end

  assign ctl.item_valid = vld_r;
  assign ctl.take_ok    = take_ok;
  assign item           = data_r;

endmodule

`default_nettype wire

// ----- design/mrs_core.sv -----
// Supervisor state machine: mission state registers, next state and request logic.
`default_nettype none

module mrs_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mrs_pkg::pipe_ctl_t        ctl,
  input  wire mrs_pkg::in_item_t         item,
  input  wire logic [mrs_pkg::REQ_W-1:0] req_specials,
  output mrs_pkg::out_item_t             result
);

  mrs_pkg::mode_t   mode_r, mode_nxt;
  mrs_pkg::reason_t reason_r, reason_nxt;
  logic             plan_asked_r, plan_asked_nxt;
  logic             run_asked_r, run_asked_nxt;
  logic             ret_r, ret_nxt;

  mrs_pkg::mode_t   eff_mode;     // idle promotes to search on an active update
  logic             short_count;
  logic             active_upd;   // update with the mission on and not cancelled
  logic             step;

  logic stop, blk, clr, preq, rreq;

  assign step        = ctl.item_valid && ctl.take_ok;
  assign short_count = item.specials_found < {{(mrs_pkg::FOUND_W-mrs_pkg::REQ_W){1'b0}},
                                              req_specials};
  assign eff_mode    = (mode_r == mrs_pkg::MODE_IDLE) ? mrs_pkg::MODE_SEARCH : mode_r;
  assign active_upd  = (item.cmd == mrs_pkg::CMD_UPDATE) && item.mission_on &&
                       (mode_r != mrs_pkg::MODE_CANCEL);

  // Next state
  always_comb begin
    mode_nxt       = mode_r;
    reason_nxt     = reason_r;
    plan_asked_nxt = plan_asked_r;
    run_asked_nxt  = run_asked_r;
    ret_nxt        = ret_r;
    unique case (item.cmd)
      mrs_pkg::CMD_CANCEL: begin
        mode_nxt   = mrs_pkg::MODE_CANCEL;
        reason_nxt = mrs_pkg::RSN_CANCEL;
        ret_nxt    = 1'b0;
      end
      mrs_pkg::CMD_RESET: begin
        mode_nxt       = mrs_pkg::MODE_IDLE;
        reason_nxt     = mrs_pkg::RSN_NONE;
        plan_asked_nxt = 1'b0;
        run_asked_nxt  = 1'b0;
        ret_nxt        = 1'b0;
      end
      mrs_pkg::CMD_UPDATE: begin
        if (!item.mission_on && mode_r != mrs_pkg::MODE_CANCEL) begin
          mode_nxt       = mrs_pkg::MODE_IDLE;
          reason_nxt     = mrs_pkg::RSN_NONE;
          plan_asked_nxt = 1'b0;
          run_asked_nxt  = 1'b0;
          ret_nxt        = 1'b0;
        end else if (mode_r != mrs_pkg::MODE_CANCEL) begin
          mode_nxt = eff_mode;
          if (mode_r == mrs_pkg::MODE_IDLE) begin
            reason_nxt = mrs_pkg::RSN_NONE;
          end
          unique case (eff_mode)
            mrs_pkg::MODE_SEARCH: begin
              if (item.no_frontier && short_count) begin
                mode_nxt   = mrs_pkg::MODE_ERROR;
                reason_nxt = mrs_pkg::RSN_NOFRONT;
              end else if (!short_count) begin
                plan_asked_nxt = 1'b0;
                run_asked_nxt  = 1'b0;
                mode_nxt       = mrs_pkg::MODE_WAIT;
              end
            end
            mrs_pkg::MODE_WAIT: begin
              if (item.nav_idle) begin
                mode_nxt       = mrs_pkg::MODE_PLAN;
                ret_nxt        = 1'b1;
                plan_asked_nxt = 1'b1;
              end
            end
            mrs_pkg::MODE_PLAN: begin
              ret_nxt = 1'b1;
              if (!item.home_known) begin
                mode_nxt   = mrs_pkg::MODE_ERROR;
                reason_nxt = mrs_pkg::RSN_BADSTART;
              end else if (item.at_home) begin
                mode_nxt   = mrs_pkg::MODE_DONE;
                reason_nxt = mrs_pkg::RSN_RETURNED;
                ret_nxt    = 1'b0;
              end else if (item.plan_ready) begin
                mode_nxt      = mrs_pkg::MODE_EXEC;
                run_asked_nxt = 1'b1;
              end
            end
            mrs_pkg::MODE_EXEC: begin
              ret_nxt = 1'b1;
              if (!item.plan_running) begin
                ret_nxt = 1'b0;
                if (item.at_home) begin
                  mode_nxt   = mrs_pkg::MODE_DONE;
                  reason_nxt = mrs_pkg::RSN_RETURNED;
                end else begin
                  mode_nxt   = mrs_pkg::MODE_ERROR;
                  reason_nxt = mrs_pkg::RSN_NOROUTE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Requests
  always_comb begin
    stop = 1'b0;
    blk  = 1'b0;
    clr  = 1'b0;
    preq = 1'b0;
    rreq = 1'b0;
    if (active_upd) begin
      unique case (eff_mode)
        mrs_pkg::MODE_SEARCH: begin
          stop = item.no_frontier && short_count;
          blk  = !short_count;
          clr  = !short_count;
        end
        mrs_pkg::MODE_WAIT: begin
          blk  = 1'b1;
          preq = item.nav_idle && !plan_asked_r;
        end
        mrs_pkg::MODE_PLAN: begin
          blk  = 1'b1;
          stop = !item.home_known || item.at_home;
          rreq = item.home_known && !item.at_home && item.plan_ready && !run_asked_r;
        end
        mrs_pkg::MODE_EXEC: begin
          blk  = 1'b1;
          stop = !item.plan_running;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= mrs_pkg::MODE_IDLE;
      reason_r     <= mrs_pkg::RSN_NONE;
      plan_asked_r <= 1'b0;
      run_asked_r  <= 1'b0;
      ret_r        <= 1'b0;
    end else if (step) begin
      mode_r       <= mode_nxt;
      reason_r     <= reason_nxt;
      plan_asked_r <= plan_asked_nxt;
      run_asked_r  <= run_asked_nxt;
      ret_r        <= ret_nxt;
    end
  end

  assign result.mode          = mode_nxt;
  assign result.reason        = reason_nxt;
  assign result.stop_autonomy = stop;
  assign result.stop_motors   = stop;
  assign result.block_actions = blk;
  assign result.clear_plan    = clr;
  assign result.plan_return   = preq;
  assign result.run_return    = rreq;
  assign result.returning     = ret_nxt;

endmodule

`default_nettype wire

// ----- design/mrs_out_stage.sv -----
// Result register: holds a finished beat until the consumer releases its stall.
`default_nettype none

module mrs_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_valid,
  input  wire mrs_pkg::out_item_t  result,
  output logic                     take_ok,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mrs_pkg::out_item_t       out_data
);

  logic               vld_r;
  mrs_pkg::out_item_t data_r;

  assign take_ok = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take_ok) begin
      vld_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_ok && item_valid) begin
      data_r <= result;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ----- design/mrs_checker.sv -----
// Port-level checks for the mission return supervisor, bound to the top level.
`default_nettype none

module mrs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire mrs_pkg::out_item_t out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // Cancelled mode carries the cancel reason, no requests and no return
  a_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mode == mrs_pkg::MODE_CANCEL |->
      out_data.reason == mrs_pkg::RSN_CANCEL && !out_data.returning &&
      !out_data.stop_motors && !out_data.block_actions && !out_data.plan_return)
    else $error("cancel beat inconsistent");

  // Plan request only on entry to return planning
  a_plan_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.plan_return |->
      out_data.mode == mrs_pkg::MODE_PLAN && out_data.returning && out_data.block_actions)
    else $error("plan request outside return planning");

  // Run request only on entry to return execution
  a_run_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_return |->
      out_data.mode == mrs_pkg::MODE_EXEC && out_data.returning)
    else $error("run request outside return execution");

  // Idle carries no reason and no return
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mode == mrs_pkg::MODE_IDLE |->
      out_data.reason == mrs_pkg::RSN_NONE && !out_data.returning &&
      out_data.stop_autonomy == out_data.stop_motors)
    else $error("idle beat inconsistent");

endmodule

bind mission_return_supervisor_fsm_top mrs_checker u_mrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- bench/mission_return_supervisor_fsm_top_test.sv -----
// Self-checking bench for the mission return supervisor: scripted and random beats.
module mission_return_supervisor_fsm_top_test;
  import mrs_pkg::*;

  // Command code the package leaves unnamed; the block must ignore it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned PHASES        = 6;
  localparam int unsigned RANDOM_BEATS  = 1400;
  localparam int unsigned HOLD_CYCLES   = 80;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 4;    // quiet time before a config write, with margin
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam longint     LIMIT_TIME     = 64'd10_000_000;

  // Steps of the stimulus script
  typedef enum logic [1:0] {
    STEP_BEAT,  // offer one input beat
    STEP_CFG,   // write the required count once the block is idle
    STEP_SYNC,  // sender pauses until every result has come back
    STEP_HOLD   // ask the receiver for its long hold-off
  } step_kind_t;

  typedef struct {
    step_kind_t  kind;
    in_item_t    beat;
    logic [3:0]  cfg;
    int unsigned gap;   // idle cycles after this beat
  } script_step_t;

  // ---------------------------------------------------------------------------
  // Block inputs: all start at known values
  // ---------------------------------------------------------------------------
  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      cfg_valid = 1'b0;
  logic [REQ_W-1:0] cfg_data = '0;

  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_ready;

  mission_return_supervisor_fsm_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  script_step_t mission_script[$];
  out_item_t    expected_reports[$];

  int unsigned n_sent;        // beats accepted by the block (driver side)
  int unsigned n_got = 0;     // results accepted from the block (updated with <=)
  int unsigned n_cfg;
  int unsigned errors = 0;
  int unsigned n_scripted = 0;
  int unsigned burst_left = 0; // beats still to be sent back to back
  int unsigned gap_left;
  int unsigned settle_left;
  logic        hold_go = 1'b0;

  // Mirror of the supervisor state
  mode_t       sup_mode;
  reason_t     sup_reason;
  logic        plan_sent;
  logic        run_sent;
  logic        ret_active;
  logic [3:0]  req_count;
  logic [7:0]  modes_seen = '0;
  int unsigned plan_reqs = 0;
  int unsigned run_reqs = 0;

  // ---------------------------------------------------------------------------
  // Supervisor mirror
  // ---------------------------------------------------------------------------
  function automatic logic [3:0] clamp_req(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > MAX_SPECIALS) return 4'(MAX_SPECIALS);
    return v;
  endfunction

  function automatic void clear_mission();
    sup_mode   = MODE_IDLE;
    sup_reason = RSN_NONE;
    plan_sent  = 1'b0;
    run_sent   = 1'b0;
    ret_active = 1'b0;
  endfunction

  // Advances the mirror by one beat and returns the result the block owes
  function automatic out_item_t supervise_step(input in_item_t b);
    out_item_t r;
    logic      short_count;
    logic      stop;
    r = '0;
    stop = 1'b0;
    short_count = (b.specials_found < {4'd0, req_count});
    case (b.cmd)
      CMD_CANCEL: begin
        sup_mode   = MODE_CANCEL;
        sup_reason = RSN_CANCEL;
        ret_active = 1'b0;
      end
      CMD_RESET: clear_mission();
      CMD_UPDATE: begin
        if (!b.mission_on && sup_mode != MODE_CANCEL) begin
          clear_mission();
        end else if (sup_mode != MODE_CANCEL) begin
          if (sup_mode == MODE_IDLE) begin
            sup_mode   = MODE_SEARCH;
            sup_reason = RSN_NONE;
          end
          case (sup_mode)
            MODE_SEARCH: begin
              if (b.no_frontier && short_count) begin
                sup_mode   = MODE_ERROR;
                sup_reason = RSN_NOFRONT;
                stop       = 1'b1;
              end else if (!short_count) begin
                plan_sent       = 1'b0;
                run_sent        = 1'b0;
                sup_mode        = MODE_WAIT;
                r.block_actions = 1'b1;
                r.clear_plan    = 1'b1;
              end
            end
            MODE_WAIT: begin
              r.block_actions = 1'b1;
              if (b.nav_idle) begin
                sup_mode   = MODE_PLAN;
                ret_active = 1'b1;
                if (!plan_sent) begin
                  plan_sent     = 1'b1;
                  r.plan_return = 1'b1;
                end
              end
            end
            MODE_PLAN: begin
              ret_active      = 1'b1;
              r.block_actions = 1'b1;
              if (!b.home_known) begin
                // start cell lost: error, return flag left set
                sup_mode   = MODE_ERROR;
                sup_reason = RSN_BADSTART;
                stop       = 1'b1;
              end else if (b.at_home) begin
                sup_mode   = MODE_DONE;
                sup_reason = RSN_RETURNED;
                ret_active = 1'b0;
                stop       = 1'b1;
              end else if (b.plan_ready) begin
                sup_mode = MODE_EXEC;
                if (!run_sent) begin
                  run_sent     = 1'b1;
                  r.run_return = 1'b1;
                end
              end
            end
            MODE_EXEC: begin
              ret_active      = 1'b1;
              r.block_actions = 1'b1;
              if (!b.plan_running) begin
                ret_active = 1'b0;
                sup_mode   = b.at_home ? MODE_DONE : MODE_ERROR;
                sup_reason = b.at_home ? RSN_RETURNED : RSN_NOROUTE;
                stop       = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;  // unknown command leaves everything alone
    endcase
    r.mode          = sup_mode;
    r.reason        = sup_reason;
    r.stop_autonomy = stop;
    r.stop_motors   = stop;
    r.returning     = ret_active;
    modes_seen[sup_mode] = 1'b1;
    if (r.plan_return) plan_reqs++;
    if (r.run_return) run_reqs++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Script building
  // ---------------------------------------------------------------------------
  // Idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t mk(input logic [1:0] cmd, input logic on,
                                  input logic [7:0] found, input logic nf,
                                  input logic nav, input logic hk, input logic ah,
                                  input logic pr, input logic prun);
    in_item_t b;
    b = '{cmd, on, found, nf, nav, hk, ah, pr, prun};
    return b;
  endfunction

  task automatic push_beat(input in_item_t b);
    script_step_t s;
    s.kind = STEP_BEAT;
    s.beat = b;
    s.cfg  = '0;
    if (burst_left > 0) begin
      burst_left--;
      s.gap = 0;
    end else begin
      s.gap = ($urandom_range(0, 1) == 0) ? 0 : idle_len();
      // occasional stretch with no sender idling at all
      if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(20, 60);
    end
    mission_script.push_back(s);
    n_scripted++;
  endtask

  task automatic push_ctl(input step_kind_t kind, input logic [3:0] v);
    script_step_t s;
    s.kind = kind;
    s.beat = '0;
    s.cfg  = v;
    s.gap  = 0;
    mission_script.push_back(s);
  endtask

  // One mission: search below the count, then reach it and walk the return.
  // One mission in ten is pure noise.
  task automatic gen_mission(input int unsigned req);
    int unsigned len;
    int unsigned reach;
    int unsigned roll;
    logic        noisy;
    in_item_t    b;
    len   = $urandom_range(4, 24);
    reach = $urandom_range(0, len / 2);
    noisy = ($urandom_range(0, 9) == 0);
    for (int unsigned k = 0; k < len; k++) begin
      if (noisy) begin
        b = in_item_t'($urandom());
      end else begin
        roll = $urandom_range(0, 99);
        b.cmd = (roll < 3) ? CMD_CANCEL : (roll < 5) ? CMD_RESET :
                (roll < 7) ? CMD_UNUSED : CMD_UPDATE;
        b.mission_on = ($urandom_range(0, 49) != 0);
        if (k < reach) begin
          b.specials_found = 8'($urandom_range(0, req - 1));
          b.no_frontier    = ($urandom_range(0, 99) < 15);
        end else begin
          b.specials_found = ($urandom_range(0, 99) < 85) ?
                             8'($urandom_range(req, 15)) : 8'($urandom_range(req, 255));
          b.no_frontier    = 1'($urandom_range(0, 1));
        end
        b.nav_idle     = 1'($urandom_range(0, 1));
        b.home_known   = ($urandom_range(0, 99) < 92);
        b.at_home      = ($urandom_range(0, 99) < 15);
        b.plan_ready   = 1'($urandom_range(0, 1));
        b.plan_running = ($urandom_range(0, 99) < 80);
      end
      push_beat(b);
    end
    // wind the mission down: disable, reset, or carry the state over
    roll = $urandom_range(0, 9);
    b = in_item_t'($urandom());
    if (roll < 5) begin
      b.cmd        = CMD_UPDATE;
      b.mission_on = 1'b0;
      push_beat(b);
    end else if (roll < 8) begin
      b.cmd = CMD_RESET;
      push_beat(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: walks the script, predicts each accepted beat
  // ---------------------------------------------------------------------------
  logic nxt_valid;
  logic nxt_cfg;
  logic quiet;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      cfg_valid   <= 1'b0;
      in_data     <= '0;
      cfg_data    <= '0;
      n_sent      = 0;
      n_cfg       = 0;
      gap_left    = 0;
      settle_left = SETTLE_CYCLES;
      req_count   = 4'd1;
      clear_mission();
    end else begin
      nxt_valid = in_valid;
      nxt_cfg   = cfg_valid;
      if (in_valid && !in_stall) begin
        expected_reports.push_back(supervise_step(in_data));
        n_sent++;
        nxt_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        req_count = clamp_req(cfg_data);
        n_cfg++;
        nxt_cfg = 1'b0;
      end
      // n_got is updated with <=, so this reads the value from before the edge
      quiet = (n_got == n_sent);
      if (!nxt_valid && !nxt_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (mission_script.size() != 0) begin
          case (mission_script[0].kind)
            STEP_BEAT: begin
              nxt_valid = 1'b1;
              in_data  <= mission_script[0].beat;
              gap_left  = mission_script[0].gap;
              void'(mission_script.pop_front());
            end
            STEP_CFG: begin
              // write only once the block has drained and settled
              if (!quiet) begin
                settle_left = SETTLE_CYCLES;
              end else if (settle_left > 0) begin
                settle_left--;
              end else begin
                nxt_cfg     = 1'b1;
                cfg_data   <= mission_script[0].cfg;
                settle_left = SETTLE_CYCLES;
                void'(mission_script.pop_front());
              end
            end
            STEP_SYNC: begin
              if (quiet) void'(mission_script.pop_front());
            end
            default: begin
              hold_go <= 1'b1;
              void'(mission_script.pop_front());
            end
          endcase
        end
      end
      in_valid  <= nxt_valid;
      cfg_valid <= nxt_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: random stalls, calm stretches, one long hold-off
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  int unsigned flow_left;
  int unsigned stall_roll;
  logic        hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      flow_left  = 0;
      hold_done  = 1'b0;
    end else if (hold_go && !hold_done) begin
      // counted here so the sender keeps offering beats meanwhile
      hold_done  = 1'b1;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (flow_left > 0) begin
      flow_left--;
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 25) begin
        stall_left = idle_len() - 1;
        out_stall <= 1'b1;
      end else begin
        if (stall_roll < 28) flow_left = $urandom_range(30, 120);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  out_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        check_field("mode", 8'(want.mode), 8'(out_data.mode));
        check_field("reason", 8'(want.reason), 8'(out_data.reason));
        check_field("stop_autonomy", 8'(want.stop_autonomy), 8'(out_data.stop_autonomy));
        check_field("stop_motors", 8'(want.stop_motors), 8'(out_data.stop_motors));
        check_field("block_actions", 8'(want.block_actions), 8'(out_data.block_actions));
        check_field("clear_plan", 8'(want.clear_plan), 8'(out_data.clear_plan));
        check_field("plan_return", 8'(want.plan_return), 8'(out_data.plan_return));
        check_field("run_return", 8'(want.run_return), 8'(out_data.run_return));
        check_field("returning", 8'(want.returning), 8'(out_data.returning));
      end
      n_got <= n_got + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [3:0]  cfg_plan [PHASES];
    int unsigned per_phase;
    int unsigned phase_start;
    int unsigned req;

    // Scripted opening with the reset count of one: every mode, every exit
    push_beat(mk(CMD_UNUSED, 1, 8'hFF, 1, 1, 1, 1, 1, 1));  // ignored in idle
    push_beat(mk(CMD_UPDATE, 0, 8'h00, 0, 0, 0, 0, 0, 0));  // disabled, stays idle
    push_beat(mk(CMD_UPDATE, 1, 8'h00, 1, 0, 0, 0, 0, 0));  // frontier gone early
    push_beat(mk(CMD_UPDATE, 1, 8'h00, 0, 1, 1, 0, 1, 1));  // error holds
    push_beat(mk(CMD_UPDATE, 0, 8'h00, 0, 0, 0, 0, 0, 0));  // back to idle
    push_beat(mk(CMD_UPDATE, 1, 8'h01, 0, 0, 1, 0, 0, 1));  // count reached
    push_beat(mk(CMD_UPDATE, 1, 8'h01, 0, 0, 1, 0, 0, 1));  // action still busy
    push_beat(mk(CMD_UPDATE, 1, 8'h01, 0, 1, 1, 0, 0, 1));  // plan request
    push_beat(mk(CMD_UPDATE, 1, 8'h01, 0, 1, 1, 0, 0, 1));  // plan not loaded yet
    push_beat(mk(CMD_UPDATE, 1, 8'h01, 0, 1, 1, 0, 1, 1));  // run request
    push_beat(mk(CMD_UPDATE, 1, 8'h01, 0, 1, 1, 0, 1, 1));  // executing
    push_beat(mk(CMD_UPDATE, 1, 8'h01, 0, 1, 1, 0, 1, 0));  // no route
    push_beat(mk(CMD_RESET, 1, 8'h00, 0, 0, 0, 0, 0, 0));
    push_beat(mk(CMD_UPDATE, 1, 8'hFF, 1, 0, 1, 0, 0, 1));
    push_beat(mk(CMD_UPDATE, 1, 8'hFF, 0, 1, 1, 0, 0, 1));
    push_beat(mk(CMD_UPDATE, 1, 8'hFF, 0, 1, 0, 0, 0, 1));  // start cell invalid
    push_beat(mk(CMD_UPDATE, 0, 8'hFF, 0, 1, 1, 0, 0, 1));
    push_beat(mk(CMD_UPDATE, 1, 8'hFF, 0, 0, 1, 0, 0, 1));
    push_beat(mk(CMD_UPDATE, 1, 8'hFF, 0, 1, 1, 0, 0, 1));
    push_beat(mk(CMD_UPDATE, 1, 8'hFF, 0, 1, 1, 1, 0, 1));  // arrived while planning
    push_beat(mk(CMD_UPDATE, 1, 8'hFF, 0, 1, 1, 1, 1, 1));  // done holds
    push_beat(mk(CMD_CANCEL, 1, 8'hFF, 0, 1, 1, 1, 1, 1));
    push_beat(mk(CMD_UPDATE, 1, 8'h00, 0, 0, 0, 0, 0, 0));  // cancel is sticky
    push_beat(mk(CMD_UPDATE, 0, 8'h00, 0, 0, 0, 0, 0, 0));  // even when disabled
    push_beat(mk(CMD_RESET, 0, 8'h00, 0, 0, 0, 0, 0, 0));

    // Random phases, each under its own required count; zero checks the clamp
    cfg_plan[0] = 4'd0;
    cfg_plan[1] = 4'd15;
    cfg_plan[2] = 4'($urandom_range(2, 14));
    cfg_plan[3] = 4'd1;
    cfg_plan[4] = 4'($urandom_range(0, 15));
    cfg_plan[5] = 4'd15;
    per_phase = RANDOM_BEATS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      push_ctl(STEP_CFG, cfg_plan[p]);
      req = clamp_req(cfg_plan[p]);
      phase_start = n_scripted;
      if (p == 1) begin
        // long receiver hold-off against a back-to-back sender
        push_ctl(STEP_HOLD, '0);
        burst_left = 50;
      end
      while (n_scripted - phase_start < per_phase) begin
        gen_mission(req);
        if (p == 3 && n_scripted - phase_start >= per_phase / 2 &&
            n_scripted - phase_start < per_phase / 2 + 24) begin
          push_ctl(STEP_SYNC, '0);
        end
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (mission_script.size() != 0 || in_valid || cfg_valid || n_got != n_sent)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_reports.size() != 0) begin
      $error("%0d results never arrived", expected_reports.size());
      errors++;
    end
    $display("Covered %0d beats under %0d count settings, %0d plan and %0d run requests.",
             n_sent, n_cfg, plan_reqs, run_reqs);
    $display("Modes reached (one bit per mode): %b, results checked: %0d, mismatches: %0d",
             modes_seen, n_got, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #(LIMIT_TIME);
    $display("timeout: %0d of %0d results back", n_got, n_sent);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mrs_pkg.sv
design/mrs_cfg.sv
design/mrs_in_stage.sv
design/mrs_core.sv
design/mrs_out_stage.sv
design/mission_return_supervisor_fsm_top.sv
design/mrs_checker.sv
bench/mission_return_supervisor_fsm_top_test.sv
